// ===== rtl/ngva_pkg.sv =====
// Shared types and constants for the noise gate and voice activity unit.
package ngva_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int AMP_W    = 16;
    localparam int PCT_W    = 7;
    localparam int TMO_W    = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_GATE_AMPLITUDE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOUD_AMPLITUDE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACTIVATE_PERCENT = 3'd2;
    localparam logic [IDX_W-1:0] REG_HOLD_PERCENT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_SILENCE_TIMEOUT  = 3'd4;

    localparam logic [AMP_W-1:0] GATE_AMPLITUDE_RST   = 16'd328;
    localparam logic [AMP_W-1:0] LOUD_AMPLITUDE_RST   = 16'd1036;
    localparam logic [PCT_W-1:0] ACTIVATE_PERCENT_RST = 7'd70;
    localparam logic [PCT_W-1:0] HOLD_PERCENT_RST     = 7'd30;
    localparam logic [TMO_W-1:0] SILENCE_TIMEOUT_RST  = 16'd1000;

    // Reciprocal of ten scaled by 2^19; exact for magnitudes up to 43690.
    localparam logic [MAG_W-1:0] RECIP_TEN   = 17'd52429;
    localparam int               RECIP_SHIFT = 19;

    typedef struct packed {
        logic [AMP_W-1:0] gate_amplitude;
        logic [AMP_W-1:0] loud_amplitude;
        logic [PCT_W-1:0] activate_percent;
        logic [PCT_W-1:0] hold_percent;
        logic [TMO_W-1:0] silence_timeout_ms;
    } ngva_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gated_sample;
        logic                       frame_end;
        logic                       gate_open;
        logic                       voice_active;
        logic                       send_frame;
    } ngva_result_t;

endpackage

// ===== rtl/ngva_regs.sv =====
// APB-style configuration register file for the noise gate and voice activity unit.
module ngva_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ngva_pkg::ADDR_W-1:0]  paddr,
    input  logic [ngva_pkg::DATA_W-1:0]  pwdata,
    output logic [ngva_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ngva_pkg::ngva_cfg_t          cfg
);
    import ngva_pkg::*;

    ngva_cfg_t        cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_amplitude     <= GATE_AMPLITUDE_RST;
            cfg_reg.loud_amplitude     <= LOUD_AMPLITUDE_RST;
            cfg_reg.activate_percent   <= ACTIVATE_PERCENT_RST;
            cfg_reg.hold_percent       <= HOLD_PERCENT_RST;
            cfg_reg.silence_timeout_ms <= SILENCE_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GATE_AMPLITUDE:   cfg_reg.gate_amplitude     <= pwdata[AMP_W-1:0];
                REG_LOUD_AMPLITUDE:   cfg_reg.loud_amplitude     <= pwdata[AMP_W-1:0];
                REG_ACTIVATE_PERCENT: cfg_reg.activate_percent   <= pwdata[PCT_W-1:0];
                REG_HOLD_PERCENT:     cfg_reg.hold_percent       <= pwdata[PCT_W-1:0];
                REG_SILENCE_TIMEOUT:  cfg_reg.silence_timeout_ms <= pwdata[TMO_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GATE_AMPLITUDE:   prdata = DATA_W'(cfg_reg.gate_amplitude);
            REG_LOUD_AMPLITUDE:   prdata = DATA_W'(cfg_reg.loud_amplitude);
            REG_ACTIVATE_PERCENT: prdata = DATA_W'(cfg_reg.activate_percent);
            REG_HOLD_PERCENT:     prdata = DATA_W'(cfg_reg.hold_percent);
            REG_SILENCE_TIMEOUT:  prdata = DATA_W'(cfg_reg.silence_timeout_ms);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== rtl/ngva_core.sv =====
// Per-sample noise gate, loud counting and frame-end voice decision with frame state.
module ngva_core #(
    parameter int FRAME_MAX = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic signed [ngva_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last_of_frame,
    input  logic [ngva_pkg::TIME_W-1:0]          now_ms,
    input  ngva_pkg::ngva_cfg_t                  cfg,
    output ngva_pkg::ngva_result_t               result
);
    import ngva_pkg::*;

    localparam int CW = $clog2(FRAME_MAX + 1);
    localparam int SW = CW + PCT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(FRAME_MAX);

    logic [CW-1:0]     frame_count_reg, frame_count_next;
    logic [CW-1:0]     loud_count_reg, loud_count_next;
    logic              any_passed_reg, any_passed_next;
    logic              voice_latched_reg, voice_latched_next;
    logic [TIME_W-1:0] last_activity_reg, last_activity_next;

    logic [MAG_W-1:0]      mag;
    logic [MAG_W-1:0]      quot;
    logic [2*MAG_W-1:0]    prod;
    logic [MAG_W-1:0]      gmag;
    logic                  attenuate;
    logic                  loud;
    logic                  room;
    logic [CW-1:0]         fc_upd;
    logic [CW-1:0]         lc_upd;
    logic                  any_upd;
    logic [SW-1:0]         share;
    logic [SW-1:0]         act_thr;
    logic [SW-1:0]         hold_thr;
    logic [TIME_W-1:0]     idle_ms;
    logic                  timed_out;
    logic signed [SAMPLE_W-1:0] g;
    logic                  voice;

    always_comb
    begin
        mag       = sample[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(sample)) : MAG_W'(sample);
        attenuate = mag < MAG_W'(cfg.gate_amplitude);
        prod      = mag * RECIP_TEN;
        quot      = MAG_W'(prod >> RECIP_SHIFT);
        if (attenuate)
        begin
            gmag = quot;
            g    = sample[SAMPLE_W-1] ? SAMPLE_W'(MAG_W'(0) - quot) : SAMPLE_W'(quot);
        end
        else
        begin
            gmag = mag;
            g    = sample;
        end
        loud    = gmag > MAG_W'(cfg.loud_amplitude);
        any_upd = any_passed_reg || !attenuate;
        room    = frame_count_reg < CNT_MAX;
        fc_upd  = room ? frame_count_reg + CW'(1) : frame_count_reg;
        lc_upd  = (room && loud && (loud_count_reg < CNT_MAX)) ?
                  loud_count_reg + CW'(1) : loud_count_reg;

        share     = SW'(lc_upd) * SW'(100);
        act_thr   = SW'(cfg.activate_percent) * SW'(fc_upd);
        hold_thr  = SW'(cfg.hold_percent) * SW'(fc_upd);
        idle_ms   = now_ms - last_activity_reg;
        timed_out = idle_ms > TIME_W'(cfg.silence_timeout_ms);

        voice_latched_next = voice_latched_reg;
        last_activity_next = last_activity_reg;
        voice              = 1'b0;
        if (!voice_latched_reg)
        begin
            if (share > act_thr)
            begin
                voice_latched_next = 1'b1;
                last_activity_next = now_ms;
            end
        end
        else if (share > hold_thr)
        begin
            last_activity_next = now_ms;
            voice              = 1'b1;
        end
        else if (timed_out)
        begin
            voice_latched_next = 1'b0;
        end
        else
        begin
            voice = 1'b1;
        end

        if (last_of_frame)
        begin
            frame_count_next = '0;
            loud_count_next  = '0;
            any_passed_next  = 1'b0;
        end
        else
        begin
            frame_count_next   = fc_upd;
            loud_count_next    = lc_upd;
            any_passed_next    = any_upd;
            voice_latched_next = voice_latched_reg;
            last_activity_next = last_activity_reg;
        end

        result.gated_sample = g;
        result.frame_end    = last_of_frame;
        result.gate_open    = last_of_frame && any_upd;
        result.voice_active = last_of_frame && voice;
        result.send_frame   = last_of_frame && voice && any_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= '0;
            loud_count_reg    <= '0;
            any_passed_reg    <= 1'b0;
            voice_latched_reg <= 1'b0;
            last_activity_reg <= '0;
        end
        else if (advance)
        begin
            frame_count_reg   <= frame_count_next;
            loud_count_reg    <= loud_count_next;
            any_passed_reg    <= any_passed_next;
            voice_latched_reg <= voice_latched_next;
            last_activity_reg <= last_activity_next;
        end
    end

endmodule

// ===== rtl/noise_gate_voice_activity_unit.sv =====
// Top level of the noise gate and voice activity unit: handshake registers and instances.
//
// The unit takes one audio sample per clock cycle while in_stall is low and returns
// one result per sample: the sample is captured in an input register, gated and
// counted by combinational logic, and the result lands in an output register.
// The frame state (sample and loud counters, gate flag, latch and activity time) is
// updated once per sample in that step, so without stalls the rate is one sample per
// cycle. The frame flags are valid only on the result that carries frame_end.
// A stalled output holds the result, and while the input register also holds a sample
// the input is stalled in the same cycle.
// No clearing pass is needed after reset.
module noise_gate_voice_activity_unit #(
    parameter int FRAME_MAX = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ngva_pkg::ADDR_W-1:0]          paddr,
    input  logic [ngva_pkg::DATA_W-1:0]          pwdata,
    output logic [ngva_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ngva_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last_of_frame,
    input  logic [ngva_pkg::TIME_W-1:0]          now_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ngva_pkg::SAMPLE_W-1:0] gated_sample,
    output logic                                 frame_end,
    output logic                                 gate_open,
    output logic                                 voice_active,
    output logic                                 send_frame
);
    import ngva_pkg::*;

    ngva_cfg_t    cfg;
    ngva_result_t result;
    ngva_result_t result_reg;

    logic                       in_valid_reg, in_valid_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [TIME_W-1:0]          now_reg;
    logic                       advance;
    logic                       accept;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    ngva_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ngva_core #(
        .FRAME_MAX (FRAME_MAX)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .sample        (sample_reg),
        .last_of_frame (last_reg),
        .now_ms        (now_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last_of_frame;
            now_reg    <= now_ms;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign gated_sample = result_reg.gated_sample;
    assign frame_end    = result_reg.frame_end;
    assign gate_open    = result_reg.gate_open;
    assign voice_active = result_reg.voice_active;
    assign send_frame   = result_reg.send_frame;

endmodule

// ===== tb/tb_noise_gate_voice_activity_unit.sv =====
// Self-checking testbench for the noise gate and voice activity unit.
module tb_noise_gate_voice_activity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_MAX   = 512;
    localparam int CYCLE_LIMIT = 300000;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 psel          = 1'b0;
    logic                                 penable       = 1'b0;
    logic                                 pwrite        = 1'b0;
    logic [ngva_pkg::ADDR_W-1:0]          paddr         = '0;
    logic [ngva_pkg::DATA_W-1:0]          pwdata        = '0;
    logic [ngva_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;
    logic                                 in_valid      = 1'b0;
    logic                                 in_stall;
    logic signed [ngva_pkg::SAMPLE_W-1:0] sample        = '0;
    logic                                 last_of_frame = 1'b0;
    logic [ngva_pkg::TIME_W-1:0]          now_ms        = '0;
    logic                                 out_valid;
    logic                                 out_stall     = 1'b0;
    logic signed [ngva_pkg::SAMPLE_W-1:0] gated_sample;
    logic                                 frame_end;
    logic                                 gate_open;
    logic                                 voice_active;
    logic                                 send_frame;

    int cfg_gate = ngva_pkg::GATE_AMPLITUDE_RST;
    int cfg_loud = ngva_pkg::LOUD_AMPLITUDE_RST;
    int cfg_act  = ngva_pkg::ACTIVATE_PERCENT_RST;
    int cfg_hold = ngva_pkg::HOLD_PERCENT_RST;
    int cfg_tmo  = ngva_pkg::SILENCE_TIMEOUT_RST;

    int                          frm_samples = 0;
    int                          frm_loud    = 0;
    logic                        frm_passed  = 1'b0;
    logic                        voice_held  = 1'b0;
    logic [ngva_pkg::TIME_W-1:0] activity_ms = '0;

    ngva_pkg::ngva_result_t expected_results[$];

    int mismatches       = 0;
    int results_checked  = 0;
    int frames_checked   = 0;
    int settings_applied = 0;
    int cycle_count      = 0;
    int burst_left       = 0;
    int gaps_on          = 1;
    int rx_hold_cycles   = 0;
    int rx_mode          = 0;
    int rx_left          = 0;

    logic [ngva_pkg::TIME_W-1:0] clock_ms = '0;

    noise_gate_voice_activity_unit #(
        .FRAME_MAX(FRAME_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last_of_frame(last_of_frame),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gated_sample (gated_sample),
        .frame_end    (frame_end),
        .gate_open    (gate_open),
        .voice_active (voice_active),
        .send_frame   (send_frame)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_noise_gate_voice_activity_unit NOT OK");
            $finish;
        end
    end

    function automatic ngva_pkg::ngva_result_t gate_and_decide(
        input logic signed [ngva_pkg::SAMPLE_W-1:0] s,
        input logic                                 last,
        input logic [ngva_pkg::TIME_W-1:0]          t
    );
        ngva_pkg::ngva_result_t      r;
        int                          sv;
        int                          gv;
        int                          mag_s;
        int                          mag_g;
        longint                      share;
        longint                      n;
        logic                        voice;
        logic [ngva_pkg::TIME_W-1:0] quiet_for;
        sv    = s;
        mag_s = (sv < 0) ? -sv : sv;
        if (mag_s < cfg_gate)
            gv = sv / 10;
        else
        begin
            gv         = sv;
            frm_passed = 1'b1;
        end
        if (frm_samples < FRAME_MAX)
        begin
            frm_samples++;
            mag_g = (gv < 0) ? -gv : gv;
            if (mag_g > cfg_loud && frm_loud < FRAME_MAX)
                frm_loud++;
        end
        r              = '0;
        r.gated_sample = gv[ngva_pkg::SAMPLE_W-1:0];
        if (last)
        begin
            share     = longint'(frm_loud) * 100;
            n         = frm_samples;
            quiet_for = t - activity_ms;
            if (!voice_held)
            begin
                if (share > longint'(cfg_act) * n)
                begin
                    voice_held  = 1'b1;
                    activity_ms = t;
                end
                voice = 1'b0;
            end
            else if (share > longint'(cfg_hold) * n)
            begin
                activity_ms = t;
                voice       = 1'b1;
            end
            else if (quiet_for > cfg_tmo)
            begin
                voice_held = 1'b0;
                voice      = 1'b0;
            end
            else
                voice = 1'b1;
            r.frame_end    = 1'b1;
            r.gate_open    = frm_passed;
            r.voice_active = voice;
            r.send_frame   = voice & frm_passed;
            frm_samples    = 0;
            frm_loud       = 0;
            frm_passed     = 1'b0;
        end
        return r;
    endfunction

    function automatic void report(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        ngva_pkg::ngva_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no sample pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report("gated_sample", want.gated_sample, gated_sample);
                    report("frame_end", want.frame_end, frame_end);
                    report("gate_open", want.gate_open, gate_open);
                    report("voice_active", want.voice_active, voice_active);
                    report("send_frame", want.send_frame, send_frame);
                    results_checked++;
                    if (want.frame_end)
                        frames_checked++;
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(gate_and_decide(sample, last_of_frame, now_ms));
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_cycles--;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= (rx_left % 4 == 0);
                default: out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    task automatic send_sample(
        input logic signed [ngva_pkg::SAMPLE_W-1:0] s,
        input logic                                 last,
        input logic [ngva_pkg::TIME_W-1:0]          t
    );
        int gap;
        if (gaps_on != 0 && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        sample        <= s;
        last_of_frame <= last;
        now_ms        <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ngva_pkg::IDX_W-1:0] idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            ngva_pkg::REG_GATE_AMPLITUDE:   cfg_gate = value & 16'hFFFF;
            ngva_pkg::REG_LOUD_AMPLITUDE:   cfg_loud = value & 16'hFFFF;
            ngva_pkg::REG_ACTIVATE_PERCENT: cfg_act  = value & 7'h7F;
            ngva_pkg::REG_HOLD_PERCENT:     cfg_hold = value & 7'h7F;
            ngva_pkg::REG_SILENCE_TIMEOUT:  cfg_tmo  = value & 16'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_and_compare(input logic [ngva_pkg::IDX_W-1:0] idx, input int want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        report("prdata", want, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        read_and_compare(ngva_pkg::REG_GATE_AMPLITUDE, cfg_gate);
        read_and_compare(ngva_pkg::REG_LOUD_AMPLITUDE, cfg_loud);
        read_and_compare(ngva_pkg::REG_ACTIVATE_PERCENT, cfg_act);
        read_and_compare(ngva_pkg::REG_HOLD_PERCENT, cfg_hold);
        read_and_compare(ngva_pkg::REG_SILENCE_TIMEOUT, cfg_tmo);
    endtask

    task automatic set_config(input int gate, input int loud, input int act, input int hold,
                              input int tmo);
        wait_idle();
        apb_write(ngva_pkg::REG_GATE_AMPLITUDE, gate);
        apb_write(ngva_pkg::REG_LOUD_AMPLITUDE, loud);
        apb_write(ngva_pkg::REG_ACTIVATE_PERCENT, act);
        apb_write(ngva_pkg::REG_HOLD_PERCENT, hold);
        apb_write(ngva_pkg::REG_SILENCE_TIMEOUT, tmo);
        check_registers();
        settings_applied++;
    endtask

    function automatic logic signed [ngva_pkg::SAMPLE_W-1:0] pick_sample(input int loud_pct);
        int          m;
        logic [31:0] v;
        if ($urandom_range(0, 99) < loud_pct)
            m = $urandom_range(cfg_loud, 32768);
        else
        begin
            case ($urandom_range(0, 5))
                0: m = cfg_gate + int'($urandom_range(0, 4)) - 2;
                1: m = cfg_loud + int'($urandom_range(0, 4)) - 2;
                2: m = 10 * cfg_loud + int'($urandom_range(0, 20)) - 10;
                3:
                begin
                    v = $urandom;
                    return v[ngva_pkg::SAMPLE_W-1:0];
                end
                4: m = ($urandom_range(0, 1) != 0) ? 32768 : $urandom_range(0, 1);
                default: m = $urandom_range(0, 400);
            endcase
        end
        if (m < 0)
            m = 0;
        if (m > 32768)
            m = 32768;
        v = ($urandom_range(0, 1) != 0) ? -m : m;
        return v[ngva_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic run_random_frames(input int target);
        int sent;
        int len;
        int loud_pct;
        sent = 0;
        while (sent < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0: loud_pct = 0;
                1: loud_pct = 20;
                2: loud_pct = 50;
                3: loud_pct = 80;
                default: loud_pct = 100;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: clock_ms = clock_ms + $urandom_range(0, 40);
                5, 6, 7: clock_ms = clock_ms + cfg_tmo + int'($urandom_range(0, 4)) - 2;
                8: clock_ms = clock_ms + $urandom_range(0, 65535);
                default: clock_ms = $urandom;
            endcase
            for (int k = 0; k < len; k++)
                send_sample(pick_sample(loud_pct), k == len - 1,
                            (k == len - 1) ? clock_ms : $urandom);
            sent += len;
        end
    endtask

    task automatic test_register_reset();
        check_registers();
    endtask

    task automatic test_gate_and_hysteresis();
        send_sample(16'sd0, 1'b0, 32'd0);
        send_sample(16'sd327, 1'b0, 32'd0);
        send_sample(-16'sd327, 1'b0, 32'd0);
        send_sample(16'sd328, 1'b0, 32'd0);
        send_sample(-16'sd32768, 1'b0, 32'd0);
        send_sample(16'sd32767, 1'b0, 32'd0);
        send_sample(16'sd10, 1'b0, 32'd0);
        send_sample(-16'sd10, 1'b0, 32'd0);
        send_sample(-16'sd1, 1'b1, 32'd100);
        send_sample(16'sd20000, 1'b0, 32'd0);
        send_sample(-16'sd20000, 1'b0, 32'd0);
        send_sample(16'sd5000, 1'b1, 32'd200);
        send_sample(16'sd2000, 1'b0, 32'd0);
        send_sample(16'sd0, 1'b1, 32'd300);
        send_sample(16'sd100, 1'b1, 32'd1300);
        send_sample(16'sd100, 1'b1, 32'd1301);
        send_sample(16'sd30000, 1'b1, 32'hFFFF_FF00);
        send_sample(16'sd0, 1'b1, 32'h0000_0100);
        send_sample(16'sd0, 1'b1, 32'h0000_0300);
    endtask

    task automatic test_long_frames();
        set_config(328, 1036, 0, 30, 1000);
        for (int k = 0; k < FRAME_MAX + 3; k++)
            send_sample((k >= FRAME_MAX) ? 16'sd20000 : 16'sd5, k == FRAME_MAX + 2, 32'd5000);
        send_sample(16'sd0, 1'b1, 32'd6000);
    endtask

    task automatic test_settings_sweep();
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(0, 0, 0, 0, 0);
                1: set_config(32768, 32768, 100, 100, 65535);
                2: set_config(16'hFFFF, 16'hFFFF, 127, 127, 16'hFFFF);
                3: set_config(ngva_pkg::GATE_AMPLITUDE_RST, ngva_pkg::LOUD_AMPLITUDE_RST,
                              ngva_pkg::ACTIVATE_PERCENT_RST, ngva_pkg::HOLD_PERCENT_RST,
                              ngva_pkg::SILENCE_TIMEOUT_RST);
                default: set_config($urandom_range(0, 4000), $urandom_range(0, 5000),
                                    $urandom_range(0, 100), $urandom_range(0, 100),
                                    $urandom_range(0, 3000));
            endcase
            if (p == 5)
                clock_ms = 32'hFFFF_F000;
            run_random_frames(8);
        end
    endtask

    task automatic test_back_pressure();
        set_config(200, 800, 40, 20, 50);
        send_sample(16'sd1000, 1'b0, 32'd0);
        rx_hold_cycles = 80;
        gaps_on        = 0;
        for (int k = 0; k < 40; k++)
        begin
            clock_ms = clock_ms + 7;
            send_sample(pick_sample(60), k % 5 == 4, clock_ms);
        end
        gaps_on = 1;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_gate_and_hysteresis();
        test_long_frames();
        test_settings_sweep();
        test_back_pressure();
        wait_idle();
        repeat (8) @(posedge clk);
        $display("Checked %0d results in %0d frames over %0d register settings,",
                 results_checked, frames_checked, settings_applied);
        $display("including a saturated long frame, time wrap and a long output hold-off.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_noise_gate_voice_activity_unit OK");
        else
            $display("tb_noise_gate_voice_activity_unit NOT OK");
        $finish;
    end

endmodule
